[rtl/lpm_pkg.sv]
// ----------------------------------------------------------------------------
// Line pattern matcher package
// Shared types, register indexes and byte classification helpers.
// ----------------------------------------------------------------------------
package lpm_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 64;

  typedef enum logic [CfgIdxW-1:0] {
    CfgPatternLength   = 3'd0,
    CfgCaseInsensitive = 3'd1,
    CfgWholeWord       = 3'd2,
    CfgPatBytes0       = 3'd3,
    CfgPatBytes1       = 3'd4,
    CfgPatBytes2       = 3'd5,
    CfgPatBytes3       = 3'd6
  } lpm_cfg_idx_e;

  localparam logic [7:0] ChrLf    = 8'h0A;
  localparam logic [7:0] ChrUpA   = 8'h41;
  localparam logic [7:0] ChrUpZ   = 8'h5A;
  localparam logic [7:0] FoldBias = 8'h20;

  // Classified text beat handed from the front end to the back end.
  typedef struct packed {
    logic [7:0] text_byte;
    logic       delim;
    logic       close;
    logic       eot;
  } lpm_item_t;

  typedef struct packed {
    logic case_fold;
    logic whole_word;
  } lpm_mode_t;

  function automatic logic is_delim(input logic [7:0] b);
    logic r;
    unique case (b)
      8'h20, 8'h2E, 8'h2C, 8'h21, 8'h3F, 8'h3B, 8'h3A, 8'h28, 8'h29,
      8'h2F, 8'h5B, 8'h5D, 8'h22, 8'h7C, 8'h27, 8'h0D, 8'h0A, 8'h00: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] fold(input logic [7:0] b, input logic en);
    logic [7:0] r;
    r = b;
    if (en && b >= ChrUpA && b <= ChrUpZ) begin
      r = b + FoldBias;
    end
    return r;
  endfunction

endpackage

[rtl/lpm_if.sv]
// ----------------------------------------------------------------------------
// Line pattern matcher channels
// Valid/ready channels for text input, line results and register writes.
// ----------------------------------------------------------------------------
interface lpm_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface lpm_out_if #(
  parameter int unsigned CountBits = 24
);
  logic                 valid;
  logic                 ready;
  logic [CountBits-1:0] line_index;
  logic                 line_matched;
  logic [CountBits-1:0] matching_lines;

  modport source (output valid, output line_index, output line_matched,
                  output matching_lines, input ready);
  modport sink (input valid, input line_index, input line_matched,
                input matching_lines, output ready);
endinterface

interface lpm_cfg_if import lpm_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

[rtl/lpm_front.sv]
// ----------------------------------------------------------------------------
// Line pattern matcher front end
// Accepts text beats and tags each byte as delimiter, line close or end of text.
// ----------------------------------------------------------------------------
module lpm_front import lpm_pkg::*; (
  lpm_in_if.sink     in_i,
  output logic       item_valid_o,
  output lpm_item_t  item_o,
  input  logic       item_ready_i
);

  assign in_i.ready   = item_ready_i;
  assign item_valid_o = in_i.valid;

  always_comb begin
    item_o.text_byte = in_i.text_byte;
    item_o.delim     = is_delim(in_i.text_byte);
    item_o.eot       = in_i.end_of_text;
    item_o.close     = in_i.end_of_text || (in_i.text_byte == ChrLf);
  end

endmodule

[rtl/lpm_queue.sv]
// ----------------------------------------------------------------------------
// Line pattern matcher item queue
// Two-entry queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module lpm_queue import lpm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_valid_i,
  output logic      push_ready_o,
  input  lpm_item_t push_item_i,
  output logic      pop_valid_o,
  input  logic      pop_ready_i,
  output lpm_item_t pop_item_o
);

  lpm_item_t  mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign pop_item_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

[rtl/lpm_cfg.sv]
// ----------------------------------------------------------------------------
// Line pattern matcher configuration
// Holds the registers and prepares a length-aligned, folded pattern image.
// ----------------------------------------------------------------------------
module lpm_cfg import lpm_pkg::*; #(
  parameter int unsigned PatternMax = 32,
  localparam int unsigned LenW      = $clog2(PatternMax + 1)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  lpm_cfg_if.sink                   cfg_i,
  output logic [LenW-1:0]           len_o,
  output lpm_mode_t                 mode_o,
  output logic [PatternMax*8-1:0]   apat_o,
  output logic [PatternMax-1:0]     care_o
);

  localparam int unsigned ShW      = $clog2(PatternMax * 8 + 1);
  localparam int unsigned RegBytes = 32;

  logic [5:0]              plen_q;
  lpm_mode_t               mode_q;
  logic [PatternMax*8-1:0] pat_q;

  logic [LenW-1:0]         len_d, len_q;
  logic [PatternMax*8-1:0] rev, shifted, apat_d, apat_q;
  logic [PatternMax-1:0]   care_d, care_q;
  logic [ShW-1:0]          shamt;
  logic                    wr;
  logic [7:0]              plen8;

  assign cfg_i.ready = 1'b1;
  assign wr          = cfg_i.valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plen_q <= 6'd1;
      mode_q <= '0;
    end else if (wr) begin
      unique case (cfg_i.index)
        CfgPatternLength:   plen_q            <= cfg_i.data[5:0];
        CfgCaseInsensitive: mode_q.case_fold  <= cfg_i.data[0];
        CfgWholeWord:       mode_q.whole_word <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  // Pattern bytes beyond the four 8-byte registers never get written.
  for (genvar p = 0; p < PatternMax; p++) begin : g_pat
    if (p < RegBytes) begin : g_wr
      localparam logic [CfgIdxW-1:0] MyIdx = CfgIdxW'(CfgPatBytes0 + p / 8);
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          pat_q[p*8 +: 8] <= 8'h00;
        end else if (wr && cfg_i.index == MyIdx) begin
          pat_q[p*8 +: 8] <= cfg_i.data[(p % 8)*8 +: 8];
        end
      end
    end else begin : g_zero
      assign pat_q[p*8 +: 8] = 8'h00;
    end
  end

  // Effective length: zero reads as one, oversize clamps to the maximum.
  always_comb begin
    plen8 = {2'b00, plen_q};
    if (plen8 == 8'd0) begin
      len_d = LenW'(1);
    end else if (plen8 > 8'(PatternMax)) begin
      len_d = LenW'(PatternMax);
    end else begin
      len_d = plen8[LenW-1:0];
    end
  end

  // Slot k of the image holds pattern byte len-1-k, so slot k lines up with
  // the window byte that arrived k beats ago.
  always_comb begin
    for (int k = 0; k < PatternMax; k++) begin
      rev[k*8 +: 8] = pat_q[(PatternMax-1-k)*8 +: 8];
    end
    shamt   = ShW'((PatternMax - int'(len_d)) * 8);
    shifted = rev >> shamt;
    for (int k = 0; k < PatternMax; k++) begin
      care_d[k]       = (k < int'(len_d));
      apat_d[k*8 +: 8] = fold(shifted[k*8 +: 8], mode_q.case_fold);
    end
  end

  always_ff @(posedge clk_i) begin
    len_q  <= len_d;
    apat_q <= apat_d;
    care_q <= care_d;
  end

  assign len_o  = len_q;
  assign mode_o = mode_q;
  assign apat_o = apat_q;
  assign care_o = care_q;

endmodule

[rtl/lpm_back.sv]
// ----------------------------------------------------------------------------
// Line pattern matcher back end
// Token window, parallel pattern compare, line counters and result register.
// ----------------------------------------------------------------------------
module lpm_back import lpm_pkg::*; #(
  parameter int unsigned PatternMax = 32,
  parameter int unsigned CountBits  = 24,
  localparam int unsigned LenW      = $clog2(PatternMax + 1)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    item_valid_i,
  output logic                    item_ready_o,
  input  lpm_item_t               item_i,
  input  logic [LenW-1:0]         len_i,
  input  lpm_mode_t               mode_i,
  input  logic [PatternMax*8-1:0] apat_i,
  input  logic [PatternMax-1:0]   care_i,
  lpm_out_if.source               out_o
);

  localparam int unsigned RunW = $clog2(PatternMax + 2);
  localparam logic [CountBits-1:0] CountMax = '1;

  logic [PatternMax*8-1:0] win_q, win_d, win_new, win_sel;
  logic [RunW-1:0]         run_q, run_d, run_inc, run_mid, len_run;
  logic                    hit_q, hit_d, hit_now, tok_hit, m;
  logic [CountBits-1:0]    line_q, line_d, hits_q, hits_d, hits_inc;
  logic [PatternMax-1:0]   eq;
  logic                    pop;

  logic                    out_valid_q, out_valid_d;
  logic [CountBits-1:0]    out_line_q, out_hits_q;
  logic                    out_hit_q;

  assign item_ready_o = !out_valid_q || out_o.ready;
  assign pop          = item_valid_i && item_ready_o;
  assign len_run      = RunW'(len_i);

  always_comb begin
    win_new[7:0] = item_i.text_byte;
    for (int k = 1; k < PatternMax; k++) begin
      win_new[k*8 +: 8] = win_q[(k-1)*8 +: 8];
    end
    // A delimiter leaves the window alone and checks the token that just ended.
    win_sel = item_i.delim ? win_q : win_new;
    for (int k = 0; k < PatternMax; k++) begin
      eq[k] = !care_i[k] || (fold(win_sel[k*8 +: 8], mode_i.case_fold) == apat_i[k*8 +: 8]);
    end
    m = &eq;

    run_inc = (run_q <= RunW'(PatternMax)) ? run_q + RunW'(1) : run_q;
    run_mid = item_i.delim ? '0 : run_inc;

    if (item_i.delim) begin
      tok_hit = mode_i.whole_word && (run_q == len_run) && m;
    end else begin
      tok_hit = (!mode_i.whole_word && (run_mid >= len_run) && m) ||
                (item_i.close && mode_i.whole_word && (run_mid == len_run) && m);
    end
    hit_now  = hit_q || tok_hit;
    hits_inc = (hit_now && hits_q != CountMax) ? hits_q + CountBits'(1) : hits_q;

    win_d  = win_q;
    run_d  = run_q;
    hit_d  = hit_q;
    line_d = line_q;
    hits_d = hits_q;
    if (pop) begin
      win_d = win_sel;
      run_d = run_mid;
      hit_d = hit_now;
      if (item_i.close) begin
        run_d  = '0;
        hit_d  = 1'b0;
        hits_d = hits_inc;
        line_d = (line_q != CountMax) ? line_q + CountBits'(1) : line_q;
      end
      if (item_i.eot) begin
        win_d  = '0;
        line_d = CountBits'(1);
        hits_d = '0;
      end
    end

    out_valid_d = out_valid_q;
    if (pop && item_i.close) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q       <= '0;
      run_q       <= '0;
      hit_q       <= 1'b0;
      line_q      <= CountBits'(1);
      hits_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      win_q       <= win_d;
      run_q       <= run_d;
      hit_q       <= hit_d;
      line_q      <= line_d;
      hits_q      <= hits_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop && item_i.close) begin
      out_line_q <= line_q;
      out_hit_q  <= hit_now;
      out_hits_q <= hits_inc;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.line_index     = out_line_q;
  assign out_o.line_matched   = out_hit_q;
  assign out_o.matching_lines = out_hits_q;

endmodule

[rtl/line_pattern_matcher_top.sv]
// A closing beat (newline or end of text) passes through the queue to the matcher, which sets
// the registered result valid when it accepts the beat; a waiting result can delay that.
// Throughput: one text beat per cycle unless a result waits; pattern slots compare in parallel.
// A two-entry queue between the classifier and the matcher absorbs up to two beats while a
// line result waits to be taken; the matcher stalls until the result register is free.
// Reset clears all line state at once; end of text restores it in-line, keeping registers.
// ----------------------------------------------------------------------------
// Line pattern matcher
// Streaming token matcher that reports per-line hit flags and counts.
// ----------------------------------------------------------------------------
module line_pattern_matcher_top import lpm_pkg::*; #(
  parameter int unsigned PatternMax = 32,
  parameter int unsigned CountBits  = 24
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  lpm_in_if.sink    in_i,
  lpm_cfg_if.sink   cfg_i,
  lpm_out_if.source out_o
);

  localparam int unsigned LenW = $clog2(PatternMax + 1);

  logic                    f_valid, f_ready, b_valid, b_ready;
  lpm_item_t               f_item, b_item;
  logic [LenW-1:0]         len;
  lpm_mode_t               mode;
  logic [PatternMax*8-1:0] apat;
  logic [PatternMax-1:0]   care;

  lpm_front u_front (
    .in_i         (in_i),
    .item_valid_o (f_valid),
    .item_o       (f_item),
    .item_ready_i (f_ready)
  );

  lpm_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_item_i  (f_item),
    .pop_valid_o  (b_valid),
    .pop_ready_i  (b_ready),
    .pop_item_o   (b_item)
  );

  lpm_cfg #(
    .PatternMax (PatternMax)
  ) u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .len_o  (len),
    .mode_o (mode),
    .apat_o (apat),
    .care_o (care)
  );

  lpm_back #(
    .PatternMax (PatternMax),
    .CountBits  (CountBits)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (b_valid),
    .item_ready_o (b_ready),
    .item_i       (b_item),
    .len_i        (len),
    .mode_i       (mode),
    .apat_i       (apat),
    .care_i       (care),
    .out_o        (out_o)
  );

endmodule

[sim/line_pattern_matcher_top_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Line pattern matcher testbench
// Streams text beats and register writes into the matcher, predicts each line
// result with a behavioral model and compares every result beat by field.
// ----------------------------------------------------------------------------
module line_pattern_matcher_top_tb;
  import lpm_pkg::*;

  localparam int unsigned PatternMax   = 32;
  localparam int unsigned CountBits    = 24;
  localparam int unsigned PhaseCount   = 12;
  localparam int unsigned SettleCycles = 4;
  localparam int unsigned QuietLimit   = 2000;
  localparam int unsigned ShownErrors  = 10;

  localparam logic [CountBits-1:0] CountTop     = '1;
  localparam logic [CfgIdxW-1:0]   CfgIdxUnused = 3'd7;
  localparam logic [7:0]           ByteLf       = 8'h0A;
  localparam logic [7:0]           ByteCr       = 8'h0D;
  localparam logic [7:0]           ByteNul      = 8'h00;
  localparam logic [7:0]           CaseBit      = 8'h20;

  typedef struct packed {
    logic [CountBits-1:0] line_index;
    logic                 line_matched;
    logic [CountBits-1:0] matching_lines;
  } line_result_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  lpm_in_if                          text_if ();
  lpm_cfg_if                         cfg_if ();
  lpm_out_if #(.CountBits(CountBits)) line_if ();

  line_pattern_matcher_top #(
    .PatternMax(PatternMax),
    .CountBits (CountBits)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (text_if),
    .cfg_i (cfg_if),
    .out_o (line_if)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Predictor copy of the registers and the line state.
  logic [5:0]           len_reg;
  logic                 fold_en;
  logic                 word_mode;
  logic [7:0]           pat_bytes [PatternMax];
  logic [7:0]           token_tail [PatternMax];
  int unsigned          token_len;
  logic                 line_hit;
  logic [CountBits-1:0] line_no;
  logic [CountBits-1:0] hit_lines;

  line_result_t pending_lines [$];

  int unsigned beats_sent;
  int unsigned lines_seen;
  int unsigned mismatches;
  int unsigned settings_used;
  int unsigned sink_hold;
  int unsigned quiet_cycles;
  bit          idle_on;

  function automatic bit splits_token(input logic [7:0] b);
    case (b)
      " ", ".", ",", "!", "?", ";", ":", "(", ")", "/", "[", "]", "\"", "|", "'",
      ByteCr, ByteLf, ByteNul: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic [7:0] fold_byte(input logic [7:0] b);
    if (fold_en && b >= "A" && b <= "Z") begin
      return b + CaseBit;
    end
    return b;
  endfunction

  function automatic int unsigned eff_len();
    if (len_reg == 0) begin
      return 1;
    end
    if (len_reg > PatternMax) begin
      return PatternMax;
    end
    return len_reg;
  endfunction

  // token_tail[0] holds the newest token byte.
  function automatic bit tail_matches(input int unsigned n);
    int unsigned j;
    for (j = 0; j < n; j++) begin
      if (fold_byte(pat_bytes[j]) != fold_byte(token_tail[n-1-j])) begin
        return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  function automatic void close_token();
    if (word_mode && token_len == eff_len() && tail_matches(eff_len())) begin
      line_hit = 1'b1;
    end
    token_len = 0;
  endfunction

  function automatic void clear_line_state();
    int unsigned i;
    for (i = 0; i < PatternMax; i++) begin
      token_tail[i] = 8'h00;
    end
    token_len = 0;
    line_hit  = 1'b0;
    line_no   = 1;
    hit_lines = 0;
  endfunction

  function automatic void reset_model();
    int unsigned i;
    len_reg   = 6'd1;
    fold_en   = 1'b0;
    word_mode = 1'b0;
    for (i = 0; i < PatternMax; i++) begin
      pat_bytes[i] = 8'h00;
    end
    clear_line_state();
  endfunction

  function automatic void apply_register(input logic [CfgIdxW-1:0] idx,
                                         input logic [CfgDataW-1:0] value);
    int base;
    int k;
    base = -1;
    case (idx)
      CfgPatternLength:   len_reg = value[5:0];
      CfgCaseInsensitive: fold_en = value[0];
      CfgWholeWord:       word_mode = value[0];
      CfgPatBytes0:       base = 0;
      CfgPatBytes1:       base = 8;
      CfgPatBytes2:       base = 16;
      CfgPatBytes3:       base = 24;
      default: ;
    endcase
    if (base >= 0) begin
      for (k = 0; k < 8; k++) begin
        pat_bytes[base+k] = value[8*k +: 8];
      end
    end
  endfunction

  // Updates the line state for one accepted text beat and queues the line
  // result when the beat closes a line.
  function automatic void track_text_beat(input logic [7:0] b, input logic eot);
    int unsigned i;
    if (splits_token(b)) begin
      close_token();
    end else begin
      for (i = PatternMax - 1; i > 0; i--) begin
        token_tail[i] = token_tail[i-1];
      end
      token_tail[0] = b;
      // Saturates one past the longest pattern.
      if (token_len <= PatternMax) begin
        token_len++;
      end
      if (!word_mode && token_len >= eff_len() && tail_matches(eff_len())) begin
        line_hit = 1'b1;
      end
    end
    if (b == ByteLf || eot) begin
      if (token_len != 0) begin
        close_token();
      end
      if (line_hit && hit_lines != CountTop) begin
        hit_lines++;
      end
      pending_lines.push_back('{line_index: line_no, line_matched: line_hit,
                                matching_lines: hit_lines});
      if (line_no != CountTop) begin
        line_no++;
      end
      line_hit  = 1'b0;
      token_len = 0;
      if (eot) begin
        clear_line_state();
      end
    end
  endfunction

  function automatic logic [7:0] flip_case(input logic [7:0] b);
    if ((b >= "a" && b <= "z") || (b >= "A" && b <= "Z")) begin
      return b ^ CaseBit;
    end
    return b;
  endfunction

  // Mostly letters of either case, sometimes any other byte that is not a
  // delimiter.
  function automatic logic [7:0] token_byte();
    logic [7:0] b;
    if ($urandom_range(0, 6) != 0) begin
      b = 8'($urandom_range("a", "z"));
      if ($urandom_range(0, 1) == 0) begin
        b = flip_case(b);
      end
    end else begin
      do begin
        b = 8'($urandom_range(0, 255));
      end while (splits_token(b));
    end
    return b;
  endfunction

  function automatic logic [7:0] pick_separator();
    case ($urandom_range(0, 16))
      0:  return " ";
      1:  return ".";
      2:  return ",";
      3:  return "!";
      4:  return "?";
      5:  return ";";
      6:  return ":";
      7:  return "(";
      8:  return ")";
      9:  return "/";
      10: return "[";
      11: return "]";
      12: return "\"";
      13: return "|";
      14: return "'";
      15: return ByteCr;
      default: return ByteNul;
    endcase
  endfunction

  task automatic send_text(input logic [7:0] b, input logic eot);
    int unsigned gap;
    gap = 0;
    if (idle_on && $urandom_range(0, 9) == 0) begin
      gap = $urandom_range(1, 11);
    end
    if (gap != 0) begin
      text_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    text_if.valid       <= 1'b1;
    text_if.text_byte   <= b;
    text_if.end_of_text <= eot;
    @(posedge clk_i);
    while (!text_if.ready) @(posedge clk_i);
    track_text_beat(b, eot);
    beats_sent++;
  endtask

  task automatic send_string(input string s, input bit eot_last);
    int i;
    for (i = 0; i < s.len(); i++) begin
      send_text(s[i], eot_last && (i == s.len() - 1));
    end
  endtask

  // Valid is left high after the beat so that back-to-back writes stay
  // continuous; the caller lowers it once the set is done.
  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    apply_register(idx, value);
  endtask

  // Upper data bits are random so that the register masking is exercised.
  task automatic program_matcher(input logic [7:0] p [PatternMax], input logic [5:0] len,
                                 input bit fold, input bit word);
    logic [CfgDataW-1:0] lane [4];
    logic [CfgDataW-1:0] value;
    int w;
    int k;
    for (w = 0; w < 4; w++) begin
      for (k = 0; k < 8; k++) begin
        lane[w][8*k +: 8] = p[8*w+k];
      end
    end
    cfg_write(CfgIdxUnused, {$urandom, $urandom});
    value = {$urandom, $urandom};
    value[5:0] = len;
    cfg_write(CfgPatternLength, value);
    value = {$urandom, $urandom};
    value[0] = fold;
    cfg_write(CfgCaseInsensitive, value);
    value = {$urandom, $urandom};
    value[0] = word;
    cfg_write(CfgWholeWord, value);
    cfg_write(CfgPatBytes0, lane[0]);
    cfg_write(CfgPatBytes1, lane[1]);
    cfg_write(CfgPatBytes2, lane[2]);
    cfg_write(CfgPatBytes3, lane[3]);
    cfg_if.valid <= 1'b0;
    settings_used++;
  endtask

  task automatic program_text(input string s, input logic [5:0] len, input bit fold,
                              input bit word);
    logic [7:0] p [PatternMax];
    int i;
    for (i = 0; i < PatternMax; i++) begin
      p[i] = (i < s.len()) ? s[i] : ByteNul;
    end
    program_matcher(p, len, fold, word);
  endtask

  // Holds the sender until every expected line has arrived and the pipeline
  // has had time to empty.
  task automatic drain();
    text_if.valid <= 1'b0;
    while (pending_lines.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic send_token();
    logic [7:0]  word_q [$];
    int unsigned n;
    int unsigned kind;
    int unsigned pre;
    int unsigned post;
    int unsigned i;
    logic [7:0]  b;
    n    = eff_len();
    kind = $urandom_range(0, 9);
    pre  = 0;
    post = 0;
    if (kind == 4 || kind == 5) begin
      pre  = $urandom_range(0, 3);
      post = $urandom_range(0, 3);
    end
    // A run of 30 to 40 token bytes ahead of the pattern, ending in the pattern.
    if (kind == 9) begin
      pre = $urandom_range(30, 40);
    end
    if (kind == 7 || kind == 8) begin
      repeat ($urandom_range(1, 8)) word_q.push_back(token_byte());
    end else begin
      repeat (pre) word_q.push_back(token_byte());
      for (i = 0; i < n; i++) begin
        b = pat_bytes[i];
        if ($urandom_range(0, 3) == 0) begin
          b = flip_case(b);
        end
        word_q.push_back(b);
      end
      if (kind == 6) begin
        word_q[pre + $urandom_range(0, n - 1)] = token_byte();
      end
      repeat (post) word_q.push_back(token_byte());
    end
    foreach (word_q[i]) begin
      send_text(word_q[i], 1'b0);
    end
  endtask

  // A well-formed line: separated tokens, then a newline or an end of text
  // that may fall on a newline, a delimiter or a token byte.
  task automatic send_line();
    int unsigned tokens;
    int unsigned t;
    tokens = $urandom_range(0, 4);
    if ($urandom_range(0, 3) == 0) begin
      send_text(pick_separator(), 1'b0);
    end
    for (t = 0; t < tokens; t++) begin
      send_token();
      if (t + 1 < tokens || $urandom_range(0, 2) == 0) begin
        repeat ($urandom_range(1, 2)) send_text(pick_separator(), 1'b0);
      end
    end
    if ($urandom_range(0, 14) != 0) begin
      send_text(ByteLf, 1'b0);
    end else begin
      case ($urandom_range(0, 2))
        0:       send_text(ByteLf, 1'b1);
        1:       send_text(pick_separator(), 1'b1);
        default: send_text(token_byte(), 1'b1);
      endcase
    end
  endtask

  task automatic send_noise();
    repeat ($urandom_range(1, 10)) begin
      send_text(8'($urandom_range(0, 255)), $urandom_range(0, 39) == 0);
    end
  endtask

  // Reset values: one pattern byte of NUL, which can never match.
  task automatic test_reset_defaults();
    send_text(8'hFF, 1'b0);
    send_text(ByteNul, 1'b0);
    send_text(ByteLf, 1'b0);
  endtask

  task automatic test_substring_folded();
    drain();
    program_text("Ab", 6'd2, 1'b1, 1'b0);
    send_string("xaB\n", 1'b0);
  endtask

  // The second line ends by end of text on a token byte, so the line count
  // restarts afterwards.
  task automatic test_whole_word();
    drain();
    program_text("ab", 6'd2, 1'b0, 1'b1);
    send_string("xab\n", 1'b0);
    send_string("ab", 1'b1);
  endtask

  task automatic test_length_limits();
    drain();
    program_text("q", 6'd0, 1'b0, 1'b1);
    send_string("q\n", 1'b0);
    send_string("qq\n", 1'b0);
  endtask

  task automatic test_delimiter_in_pattern();
    drain();
    program_text("a b", 6'd3, 1'b0, 1'b0);
    send_string("a b\n", 1'b0);
  endtask

  task automatic test_random_lines();
    logic [7:0]  p [PatternMax];
    logic [5:0]  len;
    bit          fold;
    bit          word;
    int unsigned phase;
    int unsigned goal;
    int unsigned i;
    for (phase = 0; phase < PhaseCount; phase++) begin
      fold = $urandom_range(0, 1);
      word = $urandom_range(0, 1);
      case (phase)
        0: begin
          len  = 6'd1;
          fold = 1'b0;
          word = 1'b0;
        end
        1: begin
          len  = 6'd32;
          fold = 1'b1;
          word = 1'b1;
        end
        2: begin
          len  = 6'd0;
          fold = 1'b1;
          word = 1'b1;
        end
        3: begin
          len  = 6'd63;
          fold = 1'b0;
          word = 1'b0;
        end
        default: begin
          len = ($urandom_range(0, 5) == 0) ? 6'($urandom_range(7, 16))
                                            : 6'($urandom_range(2, 6));
        end
      endcase
      drain();
      idle_on = (phase % 4 != 2) && (phase + 1 < PhaseCount);
      for (i = 0; i < PatternMax; i++) begin
        p[i] = 8'($urandom_range(0, 255));
      end
      for (i = 0; i < PatternMax && i < ((len == 0) ? 1 : len); i++) begin
        p[i] = token_byte();
      end
      program_matcher(p, len, fold, word);
      goal = beats_sent + ((eff_len() >= 16) ? 180 : 80);
      while (beats_sent < goal) begin
        if ($urandom_range(0, 5) == 0) begin
          send_noise();
        end else begin
          send_line();
        end
        if ($urandom_range(0, 15) == 0) begin
          drain();
        end
      end
    end
  endtask

  // Result sink: checks each accepted beat and stalls in random bursts.
  always @(posedge clk_i) begin
    line_result_t want;
    if (rst_ni) begin
      if (line_if.valid && line_if.ready) begin
        lines_seen++;
        if (pending_lines.size() == 0) begin
          mismatches++;
          if (mismatches <= ShownErrors) begin
            $display("unexpected line result: index %0d matched %0b count %0d",
                     line_if.line_index, line_if.line_matched, line_if.matching_lines);
          end
        end else begin
          want = pending_lines.pop_front();
          if (want.line_index !== line_if.line_index ||
              want.line_matched !== line_if.line_matched ||
              want.matching_lines !== line_if.matching_lines) begin
            mismatches++;
            if (mismatches <= ShownErrors) begin
              $display("mismatch: want idx %0d hit %0b cnt %0d, got idx %0d hit %0b cnt %0d",
                       want.line_index, want.line_matched, want.matching_lines,
                       line_if.line_index, line_if.line_matched, line_if.matching_lines);
            end
          end
        end
      end
      if (sink_hold != 0) begin
        line_if.ready <= 1'b0;
        sink_hold--;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        line_if.ready <= 1'b0;
        sink_hold = $urandom_range(0, 10);
      end else begin
        line_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((text_if.valid && text_if.ready) || (cfg_if.valid && cfg_if.ready) ||
          (line_if.valid && line_if.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QuietLimit) begin
          $display("timeout: no beat moved for %0d cycles, %0d lines outstanding",
                   quiet_cycles, pending_lines.size());
          $display("RESULT: ERROR");
          $finish;
        end
      end
    end
  end

  initial begin
    text_if.valid       = 1'b0;
    text_if.text_byte   = 8'h00;
    text_if.end_of_text = 1'b0;
    cfg_if.valid        = 1'b0;
    cfg_if.index        = CfgPatternLength;
    cfg_if.data         = '0;
    line_if.ready       = 1'b0;
    beats_sent          = 0;
    lines_seen          = 0;
    mismatches          = 0;
    settings_used       = 0;
    sink_hold           = 0;
    quiet_cycles        = 0;
    idle_on             = 1'b1;
    reset_model();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_reset_defaults();
    test_substring_folded();
    test_whole_word();
    test_length_limits();
    test_delimiter_in_pattern();
    test_random_lines();
    drain();

    $display("Sent %0d text beats and checked %0d line results under %0d register settings,",
             beats_sent, lines_seen, settings_used);
    $display("covering substring and whole-word search, case folding and out-of-range lengths.");
    if (mismatches == 0 && pending_lines.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches, %0d lines never seen", mismatches, pending_lines.size());
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/lpm_pkg.sv
rtl/lpm_if.sv
rtl/lpm_front.sv
rtl/lpm_queue.sv
rtl/lpm_cfg.sv
rtl/lpm_back.sv
rtl/line_pattern_matcher_top.sv
sim/line_pattern_matcher_top_tb.sv
